// ===== hdl/movdec_pkg.sv =====
package movdec_pkg;

    // Opcode patterns of the two supported MOV forms
    localparam logic [7:0] OPC_RM_MASK  = 8'b1111_1100;
    localparam logic [7:0] OPC_RM_VAL   = 8'b1000_1000;
    localparam logic [7:0] OPC_IMM_MASK = 8'b1111_0000;
    localparam logic [7:0] OPC_IMM_VAL  = 8'b1011_0000;

    // Addressing modes of the mod field
    localparam logic [1:0] MOD_NO_DISP = 2'd0;
    localparam logic [1:0] MOD_DISP8   = 2'd1;
    localparam logic [1:0] MOD_DISP16  = 2'd2;
    localparam logic [1:0] MOD_REG     = 2'd3;

    localparam logic [2:0] RM_DIRECT = 3'd6;

    // Byte index within an instruction (first byte is index zero)
    localparam logic [1:0] IDX_OPCODE = 2'd0;
    localparam logic [1:0] IDX_SECOND = 2'd1;
    localparam logic [1:0] IDX_THIRD  = 2'd2;
    localparam logic [1:0] IDX_FOURTH = 2'd3;

    localparam int QUEUE_DEPTH = 2;

    // Role a byte plays in its instruction, set by the front end
    typedef enum logic [2:0] {
        ROLE_NONE       = 3'd0,
        ROLE_OPCODE     = 3'd1,
        ROLE_MODRM      = 3'd2,
        ROLE_MODRM_END  = 3'd3,
        ROLE_LOW        = 3'd4,
        ROLE_DISP8_END  = 3'd5,
        ROLE_IMM8_END   = 3'd6,
        ROLE_HIGH_END   = 3'd7
    } role_t;

    typedef struct packed {
        logic [7:0] data;
        role_t      role;
    } token_t;

    function automatic logic is_rm_form(input logic [7:0] op);
        return (op & OPC_RM_MASK) == OPC_RM_VAL;
    endfunction

    function automatic logic is_imm_form(input logic [7:0] op);
        return (op & OPC_IMM_MASK) == OPC_IMM_VAL;
    endfunction

    function automatic logic role_is_end(input role_t r);
        return (r == ROLE_MODRM_END) || (r == ROLE_DISP8_END) ||
               (r == ROLE_IMM8_END) || (r == ROLE_HIGH_END);
    endfunction

endpackage

// ===== hdl/mov_instruction_byte_decoder_top.sv =====
// MOV instruction byte decoder for the 16-bit x86 encoding.
// Input channel (s_valid / s_ready / s_code_byte): one instruction-stream
// byte per transaction. Output channel (m_valid / m_ready / m_*): one decoded
// record per completed MOV instruction, register/memory with register
// (opcode 100010dw) or immediate to register (opcode 1011wrrr).
// Bytes that start neither form are dropped without a result.
// Throughput: one byte per cycle, sustained, while the receiver keeps up.
// The front end classifies each accepted byte into the two-entry token
// queue, and the back end assembles the record into the output register
// when it pops the final byte of its instruction.
// Stall: when the receiver holds m_ready low the record stays put, the back
// end stops draining the queue, and s_ready falls once the queue is full.
// Reset (aresetn low, synchronous): the byte counter returns to the first
// byte of an instruction, the queue empties and m_valid drops.
module mov_instruction_byte_decoder_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_code_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_form,
    output logic                m_to_register,
    output logic                m_wide,
    output logic [1:0]          m_mode,
    output logic [2:0]          m_reg_field,
    output logic [2:0]          m_rm_field,
    output logic                m_direct_address,
    output logic signed [15:0]  m_displacement,
    output logic [15:0]         m_operand_word
);
    import movdec_pkg::*;

    logic   q_can_push, q_push, q_pop, q_valid;
    token_t push_token, head_token;

    // front end: track byte position, tag each byte with its role
    movdec_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_code_byte (s_code_byte),
        .q_can_push  (q_can_push),
        .q_push      (q_push),
        .q_token     (push_token)
    );

    // hold tagged bytes so either side can stall on its own
    movdec_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_token (push_token),
        .can_push   (q_can_push),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_token (head_token)
    );

    // back end: collect stored bytes, emit the record on the final byte
    movdec_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .q_token          (head_token),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_form           (m_form),
        .m_to_register    (m_to_register),
        .m_wide           (m_wide),
        .m_mode           (m_mode),
        .m_reg_field      (m_reg_field),
        .m_rm_field       (m_rm_field),
        .m_direct_address (m_direct_address),
        .m_displacement   (m_displacement),
        .m_operand_word   (m_operand_word)
    );

endmodule

// ===== hdl/movdec_front.sv =====
module movdec_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_code_byte,
    input  logic                  q_can_push,
    output logic                  q_push,
    output movdec_pkg::token_t    q_token
);
    import movdec_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic [1:0] last_reg, last_next;
    logic       rm_reg, rm_next;
    role_t      role;
    logic       accept;

    assign s_ready = q_can_push;
    assign accept  = s_valid && q_can_push;

    // classify the incoming byte by its place in the instruction
    always_comb begin
        role      = ROLE_NONE;
        last_next = last_reg;
        rm_next   = rm_reg;
        case (idx_reg)
            IDX_OPCODE: begin
                if (is_rm_form(s_code_byte)) begin
                    role      = ROLE_OPCODE;
                    rm_next   = 1'b1;
                    last_next = IDX_SECOND;
                end else if (is_imm_form(s_code_byte)) begin
                    role      = ROLE_OPCODE;
                    rm_next   = 1'b0;
                    last_next = s_code_byte[3] ? IDX_THIRD : IDX_SECOND;
                end
            end
            IDX_SECOND: begin
                if (rm_reg) begin
                    case (s_code_byte[7:6])
                        MOD_NO_DISP: begin
                            if (s_code_byte[2:0] == RM_DIRECT) begin
                                role      = ROLE_MODRM;
                                last_next = IDX_FOURTH;
                            end else begin
                                role = ROLE_MODRM_END;
                            end
                        end
                        MOD_DISP8: begin
                            role      = ROLE_MODRM;
                            last_next = IDX_THIRD;
                        end
                        MOD_DISP16: begin
                            role      = ROLE_MODRM;
                            last_next = IDX_FOURTH;
                        end
                        default: role = ROLE_MODRM_END;
                    endcase
                end else begin
                    role = (last_reg == IDX_SECOND) ? ROLE_IMM8_END : ROLE_LOW;
                end
            end
            IDX_THIRD: begin
                if (rm_reg) begin
                    role = (last_reg == IDX_THIRD) ? ROLE_DISP8_END : ROLE_LOW;
                end else begin
                    role = ROLE_HIGH_END;
                end
            end
            default: role = ROLE_HIGH_END;
        endcase
    end

    // drop unknown first bytes; restart after the final byte
    always_comb begin
        idx_next = idx_reg;
        if (accept) begin
            if (role == ROLE_NONE || role_is_end(role)) begin
                idx_next = IDX_OPCODE;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    assign q_push        = accept && (role != ROLE_NONE);
    assign q_token.data  = s_code_byte;
    assign q_token.role  = role;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= IDX_OPCODE;
            last_reg <= IDX_OPCODE;
            rm_reg   <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            if (accept) begin
                last_reg <= last_next;
                rm_reg   <= rm_next;
            end
        end
    end

endmodule

// ===== hdl/movdec_queue.sv =====
module movdec_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  movdec_pkg::token_t    push_token,
    output logic                  can_push,
    input  logic                  pop,
    output logic                  head_valid,
    output movdec_pkg::token_t    head_token
);
    import movdec_pkg::*;

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    token_t            slot_reg [QUEUE_DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign can_push   = count_reg != CntW'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_token = slot_reg[rd_ptr_reg];
    assign do_push    = push && can_push;
    assign do_pop     = pop && head_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CntW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_token;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + PtrW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + PtrW'(1);
            end
        end
    end

endmodule

// ===== hdl/movdec_back.sv =====
module movdec_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  movdec_pkg::token_t    q_token,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_form,
    output logic                  m_to_register,
    output logic                  m_wide,
    output logic [1:0]            m_mode,
    output logic [2:0]            m_reg_field,
    output logic [2:0]            m_rm_field,
    output logic                  m_direct_address,
    output logic signed [15:0]    m_displacement,
    output logic [15:0]           m_operand_word
);
    import movdec_pkg::*;

    logic [7:0]  opcode_reg, modrm_reg, low_reg;
    logic        valid_reg, valid_next;
    logic        form_reg, to_reg_reg, wide_reg, direct_reg;
    logic [1:0]  mode_reg;
    logic [2:0]  regf_reg, rmf_reg;
    logic [15:0] disp_reg, word_reg;

    logic        form_next, to_reg_next, wide_next, direct_next;
    logic [1:0]  mode_next;
    logic [2:0]  regf_next, rmf_next;
    logic [15:0] disp_next, word_next;
    logic [7:0]  b;
    logic        finish;

    assign b      = q_token.data;
    assign q_pop  = q_valid && (!valid_reg || m_ready);
    assign finish = q_pop && role_is_end(q_token.role);

    // build the result record from the final byte and the stored bytes
    always_comb begin
        form_next   = 1'b0;
        to_reg_next = opcode_reg[1];
        wide_next   = opcode_reg[0];
        mode_next   = modrm_reg[7:6];
        regf_next   = modrm_reg[5:3];
        rmf_next    = modrm_reg[2:0];
        direct_next = 1'b0;
        disp_next   = '0;
        word_next   = '0;
        case (q_token.role)
            ROLE_MODRM_END: begin
                mode_next = b[7:6];
                regf_next = b[5:3];
                rmf_next  = b[2:0];
            end
            ROLE_DISP8_END: begin
                disp_next = {{8{b[7]}}, b};
            end
            ROLE_IMM8_END: begin
                form_next   = 1'b1;
                to_reg_next = 1'b1;
                wide_next   = opcode_reg[3];
                mode_next   = MOD_REG;
                regf_next   = opcode_reg[2:0];
                rmf_next    = '0;
                word_next   = {8'd0, b};
            end
            ROLE_HIGH_END: begin
                if (is_imm_form(opcode_reg)) begin
                    form_next   = 1'b1;
                    to_reg_next = 1'b1;
                    wide_next   = opcode_reg[3];
                    mode_next   = MOD_REG;
                    regf_next   = opcode_reg[2:0];
                    rmf_next    = '0;
                    word_next   = {b, low_reg};
                end else if (modrm_reg[7:6] == MOD_NO_DISP) begin
                    direct_next = 1'b1;
                    word_next   = {b, low_reg};
                end else begin
                    disp_next = {b, low_reg};
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (finish) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            case (q_token.role)
                ROLE_OPCODE: opcode_reg <= b;
                ROLE_MODRM:  modrm_reg  <= b;
                ROLE_LOW:    low_reg    <= b;
                default: ;
            endcase
        end
        if (finish) begin
            form_reg   <= form_next;
            to_reg_reg <= to_reg_next;
            wide_reg   <= wide_next;
            mode_reg   <= mode_next;
            regf_reg   <= regf_next;
            rmf_reg    <= rmf_next;
            direct_reg <= direct_next;
            disp_reg   <= disp_next;
            word_reg   <= word_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign m_valid          = valid_reg;
    assign m_form           = form_reg;
    assign m_to_register    = to_reg_reg;
    assign m_wide           = wide_reg;
    assign m_mode           = mode_reg;
    assign m_reg_field      = regf_reg;
    assign m_rm_field       = rmf_reg;
    assign m_direct_address = direct_reg;
    assign m_displacement   = disp_reg;
    assign m_operand_word   = word_reg;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import movdec_pkg::*;

    // Run shape: 10 ns clock, reset held low at the start, then a directed
    // pass over each addressing mode, a long random instruction stream and
    // a stretch in which the receiver holds off so that the decoder fills.
    localparam int RESET_CYCLES    = 5;
    localparam int RANDOM_BYTES    = 850;
    localparam int PRESSURE_INSTRS = 30;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 8;
    localparam int STALL_LIMIT     = 3000;

    localparam logic FORM_RM  = 1'b0;
    localparam logic FORM_IMM = 1'b1;

    // One decoded MOV record, laid out as the result channel presents it
    typedef struct packed {
        logic               form;
        logic               to_register;
        logic               wide;
        logic [1:0]         mode;
        logic [2:0]         reg_field;
        logic [2:0]         rm_field;
        logic               direct_address;
        logic signed [15:0] displacement;
        logic [15:0]        operand_word;
    } mov_record_t;

    // Receiver behaviour; a fresh one is drawn whenever the current one runs out
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_HALF,
        RX_SPARSE
    } rx_style_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_code_byte;
    logic               m_valid;
    logic               m_ready;
    logic               m_form;
    logic               m_to_register;
    logic               m_wide;
    logic [1:0]         m_mode;
    logic [2:0]         m_reg_field;
    logic [2:0]         m_rm_field;
    logic               m_direct_address;
    logic signed [15:0] m_displacement;
    logic [15:0]        m_operand_word;

    // Decoder state as the testbench tracks it; starts in its reset state
    logic [1:0]  dec_idx    = IDX_OPCODE;
    logic [2:0]  dec_len    = 3'd1;
    logic [7:0]  dec_opcode = 8'h00;
    logic [7:0]  dec_modrm  = 8'h00;
    logic [7:0]  dec_low    = 8'h00;

    mov_record_t pending_records[$];
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;
    bit          hold_off_req   = 1'b0;

    mov_instruction_byte_decoder_top u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_code_byte      (s_code_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_form           (m_form),
        .m_to_register    (m_to_register),
        .m_wide           (m_wide),
        .m_mode           (m_mode),
        .m_reg_field      (m_reg_field),
        .m_rm_field       (m_rm_field),
        .m_direct_address (m_direct_address),
        .m_displacement   (m_displacement),
        .m_operand_word   (m_operand_word)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Decode prediction
    // ------------------------------------------------------------------

    // Register/memory form: d and w come straight from the opcode, the
    // three fields from the mod-reg-r/m byte.
    function automatic mov_record_t rm_record(input logic [7:0] op, input logic [7:0] modrm,
                                              input logic [15:0] disp, input logic [15:0] word,
                                              input logic direct);
        mov_record_t rec;
        rec.form           = FORM_RM;
        rec.to_register    = op[1];
        rec.wide           = op[0];
        rec.mode           = modrm[7:6];
        rec.reg_field      = modrm[5:3];
        rec.rm_field       = modrm[2:0];
        rec.direct_address = direct;
        rec.displacement   = disp;
        rec.operand_word   = word;
        return rec;
    endfunction

    // Immediate form: the register is always the destination, mode reads
    // as register, and only w, the register number and the data vary.
    function automatic mov_record_t imm_record(input logic [7:0] op, input logic [15:0] word);
        mov_record_t rec;
        rec                = '0;
        rec.form           = FORM_IMM;
        rec.to_register    = 1'b1;
        rec.wide           = op[3];
        rec.mode           = MOD_REG;
        rec.reg_field      = op[2:0];
        rec.operand_word   = word;
        return rec;
    endfunction

    // Advance the tracked decoder by one accepted byte; queue the record
    // when the byte completes an instruction.
    task automatic decode_stream_byte(input logic [7:0] b);
        logic op_rm;
        logic op_imm;
        op_rm  = (dec_opcode & OPC_RM_MASK) == OPC_RM_VAL;
        op_imm = (dec_opcode & OPC_IMM_MASK) == OPC_IMM_VAL;
        case (dec_idx)
            IDX_OPCODE: begin
                // Anything that starts neither form leaves the length at one
                if ((b & OPC_RM_MASK) == OPC_RM_VAL) begin
                    dec_opcode = b;
                    dec_len    = 3'd2;
                end else if ((b & OPC_IMM_MASK) == OPC_IMM_VAL) begin
                    dec_opcode = b;
                    dec_len    = b[3] ? 3'd3 : 3'd2;
                end
            end
            IDX_SECOND: begin
                if (op_rm) begin
                    dec_modrm = b;
                    if (b[7:6] == MOD_NO_DISP && b[2:0] == RM_DIRECT) begin
                        dec_len = 3'd4;
                    end else if (b[7:6] == MOD_DISP8) begin
                        dec_len = 3'd3;
                    end else if (b[7:6] == MOD_DISP16) begin
                        dec_len = 3'd4;
                    end else begin
                        pending_records.push_back(rm_record(dec_opcode, b, 16'h0000,
                                                            16'h0000, 1'b0));
                    end
                end else if (op_imm) begin
                    if (dec_len == 3'd2) begin
                        pending_records.push_back(imm_record(dec_opcode, {8'h00, b}));
                    end else begin
                        dec_low = b;
                    end
                end
            end
            IDX_THIRD: begin
                if (op_rm) begin
                    if (dec_len == 3'd3) begin
                        // Byte displacement: sign-extend to 16 bits
                        pending_records.push_back(rm_record(dec_opcode, dec_modrm,
                                                            {{8{b[7]}}, b}, 16'h0000, 1'b0));
                    end else begin
                        dec_low = b;
                    end
                end else if (op_imm) begin
                    pending_records.push_back(imm_record(dec_opcode, {b, dec_low}));
                end
            end
            default: begin
                if (op_rm) begin
                    // Mode 0 here can only be the direct-address case
                    if (dec_modrm[7:6] == MOD_NO_DISP) begin
                        pending_records.push_back(rm_record(dec_opcode, dec_modrm, 16'h0000,
                                                            {b, dec_low}, 1'b1));
                    end else begin
                        pending_records.push_back(rm_record(dec_opcode, dec_modrm,
                                                            {b, dec_low}, 16'h0000, 1'b0));
                    end
                end
            end
        endcase
        if ({1'b0, dec_idx} + 3'd1 >= dec_len) begin
            dec_idx    = IDX_OPCODE;
            dec_len    = 3'd1;
            dec_opcode = 8'h00;
            dec_modrm  = 8'h00;
            dec_low    = 8'h00;
        end else begin
            dec_idx = dec_idx + 2'd1;
        end
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Present one byte at the falling edge and hold it until the
    // transaction completes; valid stays high for a following byte.
    task automatic send_byte(input logic [7:0] b);
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_code_byte <= b;
        do @(posedge aclk); while (!s_ready);
        decode_stream_byte(b);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    // Payload bytes lean towards the sign and range boundaries
    function automatic logic [7:0] random_data_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Build one instruction: mostly well-formed MOVs of either form, with
    // the odd stray byte that may itself start an instruction and so
    // swallow the head of the next one.
    task automatic make_instruction(output logic [7:0] bytes[$]);
        int         kind;
        int         extra;
        logic [7:0] op;
        logic [1:0] mode;
        logic [2:0] rm;
        bytes = {};
        kind  = $urandom_range(0, 19);
        if (kind < 2) begin
            bytes.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 12) begin
            op   = OPC_RM_VAL | 8'($urandom_range(0, 3));
            mode = 2'($urandom_range(0, 3));
            rm   = 3'($urandom_range(0, 7));
            if (mode == MOD_NO_DISP && $urandom_range(0, 2) == 0) begin
                rm = RM_DIRECT;
            end
            bytes.push_back(op);
            bytes.push_back({mode, 3'($urandom_range(0, 7)), rm});
            if (mode == MOD_DISP8) begin
                extra = 1;
            end else if (mode == MOD_DISP16 || (mode == MOD_NO_DISP && rm == RM_DIRECT)) begin
                extra = 2;
            end else begin
                extra = 0;
            end
            repeat (extra) bytes.push_back(random_data_byte());
        end else begin
            op = OPC_IMM_VAL | 8'($urandom_range(0, 15));
            bytes.push_back(op);
            bytes.push_back(random_data_byte());
            if (op[3]) begin
                bytes.push_back(random_data_byte());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Register to register, both directions and both widths
    task automatic test_register_moves();
        send_byte(8'h89); send_byte(8'hD8);
        send_byte(8'h8A); send_byte(8'hFF);
    endtask

    // No displacement, direct address, negative byte displacement and a
    // word displacement of all ones
    task automatic test_memory_modes();
        send_byte(8'h89); send_byte(8'h07);
        send_byte(8'h8A); send_byte(8'h06); send_byte(8'h34); send_byte(8'h12);
        send_byte(8'h8B); send_byte(8'h46); send_byte(8'h80);
        send_byte(8'h89); send_byte(8'h80); send_byte(8'hFF); send_byte(8'hFF);
    endtask

    // Byte immediate of zero into register 0, word of all ones into 7
    task automatic test_immediate_moves();
        send_byte(8'hB0); send_byte(8'h00);
        send_byte(8'hBF); send_byte(8'hFF); send_byte(8'hFF);
    endtask

    // Opcodes outside both forms must vanish without a record
    task automatic test_unknown_opcodes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h8C);
    endtask

    // Random stream sent in bursts with gaps between them; stray bytes
    // do not count towards the byte budget
    task automatic test_random_stream();
        logic [7:0] instr[$];
        int         sent;
        int         burst_left;
        sent       = 0;
        burst_left = 0;
        while (sent < RANDOM_BYTES) begin
            make_instruction(instr);
            foreach (instr[i]) begin
                if (burst_left == 0) begin
                    idle_cycles($urandom_range(0, 8));
                    burst_left = $urandom_range(1, 40);
                end
                send_byte(instr[i]);
                burst_left--;
            end
            if (instr.size() > 1) begin
                sent += instr.size();
            end
        end
    endtask

    // Ask the receiver to hold off, then keep offering bytes back to back
    // so that the decoder fills and drops s_ready
    task automatic test_backpressure();
        logic [7:0] instr[$];
        hold_off_req = 1'b1;
        repeat (PRESSURE_INSTRS) begin
            make_instruction(instr);
            foreach (instr[i]) send_byte(instr[i]);
        end
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Drive m_ready at the falling edge: honour a hold-off request first,
    // otherwise follow the current style until it runs out.
    initial begin
        rx_style_t style;
        int        style_left;
        m_ready    = 1'b0;
        style      = RX_ALWAYS;
        style_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge aclk);
                hold_off_req = 1'b0;
            end else begin
                if (style_left == 0) begin
                    style      = rx_style_t'($urandom_range(0, 3));
                    style_left = $urandom_range(20, 80);
                end
                style_left--;
                case (style)
                    RX_ALWAYS: m_ready <= 1'b1;
                    RX_MOSTLY: m_ready <= ($urandom_range(0, 3) != 0);
                    RX_HALF:   m_ready <= 1'($urandom_range(0, 1));
                    default:   m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each record transaction with the oldest expected record
    always @(posedge aclk) begin
        mov_record_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_records.size() == 0) begin
                $display("%0t ns: record with none expected, form %b reg %0d operand %h",
                         $time, m_form, m_reg_field, m_operand_word);
                mismatch_count++;
            end else begin
                want = pending_records.pop_front();
                check_field("form",           16'(want.form),           16'(m_form));
                check_field("to_register",    16'(want.to_register),    16'(m_to_register));
                check_field("wide",           16'(want.wide),           16'(m_wide));
                check_field("mode",           16'(want.mode),           16'(m_mode));
                check_field("reg_field",      16'(want.reg_field),      16'(m_reg_field));
                check_field("rm_field",       16'(want.rm_field),       16'(m_rm_field));
                check_field("direct_address", 16'(want.direct_address),
                            16'(m_direct_address));
                check_field("displacement",   want.displacement,        m_displacement);
                check_field("operand_word",   want.operand_word,        m_operand_word);
            end
        end
    end

    // Abort when neither channel has moved a transaction for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("** mov_instruction_byte_decoder_top: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        s_valid     = 1'b0;
        s_code_byte = 8'h00;
        aresetn     = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_register_moves();
        test_memory_modes();
        test_immediate_moves();
        test_unknown_opcodes();
        test_random_stream();
        test_backpressure();

        // Drop valid, let every expected record arrive, then let the
        // pipeline run on to show any stray record
        idle_cycles(1);
        while (pending_records.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("** mov_instruction_byte_decoder_top: PASSED **");
        end else begin
            $display("** mov_instruction_byte_decoder_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/movdec_pkg.sv
hdl/movdec_front.sv
hdl/movdec_queue.sv
hdl/movdec_back.sv
hdl/mov_instruction_byte_decoder_top.sv
sim/tb_top.sv
